[src/assert_macros.svh]
// assertion helpers for the rtl, included by cle_ctrl
// both macros sample on clk and are quiet while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define CLE_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("cle assertion failed");

// antecedent implies consequent in the same cycle
`define CLE_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cle implication failed");

`endif

[src/cle_pkg.sv]
`default_nettype none
package cle_pkg;

	localparam int BYTE_W  = 8;
	localparam int LEN_W   = 5;
	localparam int LIMIT_W = 6;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd32;

	localparam logic [BYTE_W-1:0] CH_BS  = 8'h08;
	localparam logic [BYTE_W-1:0] CH_LF  = 8'h0a;
	localparam logic [BYTE_W-1:0] CH_CR  = 8'h0d;
	localparam logic [BYTE_W-1:0] CH_ESC = 8'h1b;
	localparam logic [BYTE_W-1:0] CH_LBR = 8'h5b;
	localparam logic [BYTE_W-1:0] CH_K   = 8'h4b;
	localparam logic [BYTE_W-1:0] CH_DEL = 8'h7f;

	typedef enum logic [1:0] {
		KIND_ECHO = 2'd0,
		KIND_CHAR = 2'd1,
		KIND_END  = 2'd2,
		KIND_OVER = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [BYTE_W-1:0] byte_value;
		logic [LEN_W-1:0]  line_length;
		logic              last;
	} res_t;

	// erase echo: backspace, then erase-to-end-of-line sequence
	function automatic logic [BYTE_W-1:0] erase_byte(input logic [1:0] step);
		logic [BYTE_W-1:0] b;
		case (step)
			2'd0:    b = CH_BS;
			2'd1:    b = CH_ESC;
			2'd2:    b = CH_LBR;
			default: b = CH_K;
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

[src/cle_store.sv]
`default_nettype none
module cle_store #(
	parameter int LINE_DEPTH = 32,
	localparam int AW = $clog2(LINE_DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [7:0]    rdata
);

	logic [7:0] mem [LINE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

[src/cle_ctrl.sv]
`default_nettype none
`include "assert_macros.svh"
module cle_ctrl
	import cle_pkg::*;
#(
	parameter int LINE_DEPTH = 32,
	localparam int AW = $clog2(LINE_DEPTH),
	localparam int CW = $clog2(LINE_DEPTH + 1)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [BYTE_W-1:0]  in_byte,
	input  wire logic [LIMIT_W-1:0] limit,
	input  wire logic               slot_free,
	output logic                    push,
	output res_t                    res
);

	localparam int XW = LIMIT_W + CW;
	localparam int LW = LEN_W + CW;

	localparam logic [1:0] ESC_NONE = 2'd0;
	localparam logic [1:0] ESC_OPEN = 2'd1;
	localparam logic [1:0] ESC_CSI  = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ECHO,
		S_OVER,
		S_ERASE,
		S_CR,
		S_LF,
		S_CHAR,
		S_END
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     idx_q;
	logic [1:0]        phase_q;
	logic [1:0]        step_q;
	logic [BYTE_W-1:0] byte_q;
	logic              ovf_q;

	logic              is_cr, is_lf, is_erase, is_esc;
	logic              c_skip, c_end, c_pend, c_erase, c_plain;
	logic              room;
	logic [CW-1:0]     cnt_new;
	logic [XW-1:0]     eff_lim;
	logic              ovf;
	logic [CW-1:0]     idx_nxt;
	logic              idx_more;
	logic [LW-1:0]     len_wide;

	logic              mem_we, mem_re;
	logic [AW-1:0]     mem_raddr;
	logic [7:0]        mem_rdata;

	// byte classification for the item at the input
	always_comb begin
		is_cr    = (in_byte == CH_CR);
		is_lf    = (in_byte == CH_LF);
		is_esc   = (in_byte == CH_ESC);
		is_erase = (in_byte == CH_BS) || (in_byte == CH_DEL) || is_esc;
		c_skip   = is_lf && (count_q == '0);
		c_end    = !c_skip && (is_cr || is_lf);
		c_pend   = !c_skip && !c_end && (phase_q != ESC_NONE);
		c_erase  = !c_skip && !c_end && !c_pend && is_erase;
		c_plain  = !c_skip && !c_end && !c_pend && !is_erase;
	end

	// count update and limit check for a stored byte
	always_comb begin
		room    = (count_q < CW'(LINE_DEPTH));
		cnt_new = room ? count_q + CW'(1) : count_q;
		if (limit == '0) begin
			eff_lim = XW'(1);
		end else if (XW'(limit) > XW'(LINE_DEPTH)) begin
			eff_lim = XW'(LINE_DEPTH);
		end else begin
			eff_lim = XW'(limit);
		end
		ovf = (XW'(cnt_new) >= eff_lim);
	end

	// line playback index step
	always_comb begin
		idx_nxt  = idx_q + CW'(1);
		idx_more = (idx_nxt < count_q);
		len_wide = LW'(count_q);
	end

	assign in_ready = (state_q == S_IDLE);
	assign push     = (state_q != S_IDLE) && slot_free;

	assign mem_we    = (state_q == S_IDLE) && in_valid && c_plain && room;
	assign mem_re    = push && (((state_q == S_LF) && (count_q != '0)) ||
		((state_q == S_CHAR) && idx_more));
	assign mem_raddr = (state_q == S_LF) ? '0 : idx_nxt[AW-1:0];

	cle_store #(
		.LINE_DEPTH(LINE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(count_q[AW-1:0]),
		.wdata(in_byte),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	always_comb begin
		res.kind        = KIND_ECHO;
		res.byte_value  = '0;
		res.line_length = '0;
		res.last        = 1'b0;
		case (state_q)
			S_ECHO: begin
				res.byte_value = byte_q;
				res.last       = !ovf_q;
			end
			S_OVER: begin
				res.kind = KIND_OVER;
				res.last = 1'b1;
			end
			S_ERASE: begin
				res.byte_value = erase_byte(step_q);
				res.last       = (step_q == 2'd3);
			end
			S_CR: begin
				res.byte_value = CH_CR;
			end
			S_LF: begin
				res.byte_value = CH_LF;
			end
			S_CHAR: begin
				res.kind       = KIND_CHAR;
				res.byte_value = mem_rdata;
			end
			S_END: begin
				res.kind        = KIND_END;
				res.line_length = len_wide[LEN_W-1:0];
				res.last        = 1'b1;
			end
			default: begin
				res.kind = KIND_ECHO;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			phase_q <= ESC_NONE;
			step_q  <= '0;
			ovf_q   <= 1'b0;
			byte_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						byte_q <= in_byte;
						if (c_end) begin
							state_q <= S_CR;
						end else if (c_pend) begin
							if ((in_byte != CH_LBR) || (phase_q == ESC_CSI)) begin
								phase_q <= ESC_NONE;
							end else begin
								phase_q <= ESC_CSI;
							end
						end else if (c_erase) begin
							if (count_q != '0) begin
								count_q <= count_q - CW'(1);
								step_q  <= '0;
								state_q <= S_ERASE;
							end
							if (is_esc) begin
								phase_q <= ESC_OPEN;
							end
						end else if (c_plain) begin
							count_q <= ovf ? '0 : cnt_new;
							ovf_q   <= ovf;
							state_q <= S_ECHO;
						end
					end
				end
				S_ECHO: begin
					if (push) begin
						state_q <= ovf_q ? S_OVER : S_IDLE;
					end
				end
				S_OVER: begin
					if (push) begin
						state_q <= S_IDLE;
					end
				end
				S_ERASE: begin
					if (push) begin
						step_q <= step_q + 2'd1;
						if (step_q == 2'd3) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_CR: begin
					if (push) begin
						state_q <= S_LF;
					end
				end
				S_LF: begin
					if (push) begin
						idx_q   <= '0;
						state_q <= (count_q != '0) ? S_CHAR : S_END;
					end
				end
				S_CHAR: begin
					if (push) begin
						idx_q <= idx_nxt;
						if (!idx_more) begin
							state_q <= S_END;
						end
					end
				end
				S_END: begin
					if (push) begin
						count_q <= '0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// the line never grows past the store
	`CLE_ASSERT(a_count_bound, count_q <= CW'(LINE_DEPTH))
	// playback only reads entries inside the current line
	`CLE_ASSERT_IMP(a_idx_in_line, state_q == S_CHAR, idx_q < count_q)
	// a line end or overflow always closes the transaction group
	`CLE_ASSERT_IMP(a_end_is_last,
		push && (res.kind == KIND_END || res.kind == KIND_OVER), res.last)

endmodule
`default_nettype wire

[src/console_line_editor.sv]
// console line editor
// s_axis carries received console bytes (tdata[7:0]), one transaction per byte.
// m_axis carries results: tuser = kind (echo, line char, line end, overflow),
// tdata = byte value and line length, tlast marks the final result of a byte.
// cfg_we / cfg_wdata write line_limit; the user must do so only while the block
// is idle, which the block itself does not enforce. s_axis_tready is high only
// while the sequencer is idle. each result of a byte goes to the output register:
// a plain byte gives its echo (and an overflow result when the limit is hit), an
// erase of a character gives bs, esc, '[', 'K', a dropped escape byte gives none,
// a line end gives cr, lf, each stored character and the line end result. the
// line store read port is fetched one entry ahead, so playback moves one character
// per cycle unless the output stalls. the output register decouples the sides:
// when it is full and m_axis_tready is low the sequencer holds its result, and
// once the last result of a byte is in the register a new byte may be accepted.
// reset clears the line, the escape phase and the output valid, and sets
// line_limit to 32; the line store itself is not cleared.
`default_nettype none
module console_line_editor
	import cle_pkg::*;
#(
	parameter int LINE_DEPTH = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// config write
	input  wire logic               cfg_we,
	input  wire logic [LIMIT_W-1:0] cfg_wdata,
	// received bytes
	input  wire logic               s_axis_tvalid,
	output logic                    s_axis_tready,
	input  wire logic [7:0]         s_axis_tdata,   // [7:0] rx_byte
	// results
	output logic                    m_axis_tvalid,
	input  wire logic               m_axis_tready,
	output logic [15:0]             m_axis_tdata,   // [7:0] byte_value, [12:8] line_length
	output logic [1:0]              m_axis_tuser,   // [1:0] kind
	output logic                    m_axis_tlast
);

	logic [LIMIT_W-1:0] limit_q;
	logic               out_valid_q;
	res_t               out_q;
	res_t               res;
	logic               push;
	logic               slot_free;

	// line_limit register, plain write strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	// output slot frees up when empty or drained this cycle
	assign slot_free = !out_valid_q || m_axis_tready;

	cle_ctrl #(
		.LINE_DEPTH(LINE_DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata),
		.limit    (limit_q),
		.slot_free(slot_free),
		.push     (push),
		.res      (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (push) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, out_q.line_length, out_q.byte_value};
	assign m_axis_tuser  = out_q.kind;
	assign m_axis_tlast  = out_q.last;

endmodule
`default_nettype wire

[tb/console_line_editor_checker.sv]
`timescale 1ns / 100ps
module console_line_editor_checker
	import cle_pkg::*;
#(
	parameter int LINE_DEPTH = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [LIMIT_W-1:0] cfg_wdata,
	input  wire logic               s_axis_tvalid,
	input  wire logic               s_axis_tready,
	input  wire logic [7:0]         s_axis_tdata,
	input  wire logic               m_axis_tvalid,
	input  wire logic               m_axis_tready,
	input  wire logic [15:0]        m_axis_tdata,
	input  wire logic [1:0]         m_axis_tuser,
	input  wire logic               m_axis_tlast,
	output int                      mismatches,
	output int                      pending,
	output int                      busy_bytes,
	output int                      checked,
	output int                      overflows
);

	typedef enum logic [1:0] {
		ESC_IDLE = 2'd0,
		ESC_SEEN = 2'd1,
		ESC_CSI  = 2'd2
	} esc_t;

	logic [BYTE_W-1:0]  line_buf [LINE_DEPTH];
	int unsigned        line_count;
	esc_t               esc_state;
	logic [LIMIT_W-1:0] line_limit;
	res_t               expected_results [$];
	res_t               burst [$];
	int                 n_bad;
	int                 n_busy;
	int                 n_checked;
	int                 n_over;

	function automatic int unsigned limit_in_use();
		int unsigned lim;
		lim = line_limit;
		if (lim < 1) lim = 1;
		if (lim > LINE_DEPTH) lim = LINE_DEPTH;
		return lim;
	endfunction

	task automatic note(input kind_t k, input logic [BYTE_W-1:0] b, input int unsigned len);
		res_t r;
		r = '{kind: k, byte_value: b, line_length: LEN_W'(len), last: 1'b0};
		burst.push_back(r);
	endtask

	// works out the results of one received byte and updates the line
	task automatic edit_line(input logic [BYTE_W-1:0] ch);
		res_t r;
		burst.delete();
		if (ch == CH_CR || (ch == CH_LF && line_count != 0)) begin
			note(KIND_ECHO, CH_CR, 0);
			note(KIND_ECHO, CH_LF, 0);
			for (int unsigned i = 0; i < line_count && i < LINE_DEPTH; i++)
				note(KIND_CHAR, line_buf[i], 0);
			note(KIND_END, '0, line_count);
			line_count = 0;
		end else if (ch == CH_LF) begin
			// lf on an empty line is dropped
		end else if (esc_state != ESC_IDLE) begin
			if (ch != CH_LBR || esc_state == ESC_CSI)
				esc_state = ESC_IDLE;
			else
				esc_state = ESC_CSI;
		end else if (ch == CH_BS || ch == CH_DEL || ch == CH_ESC) begin
			if (line_count > 0) begin
				line_count--;
				note(KIND_ECHO, CH_BS, 0);
				note(KIND_ECHO, CH_ESC, 0);
				note(KIND_ECHO, CH_LBR, 0);
				note(KIND_ECHO, CH_K, 0);
			end
			if (ch == CH_ESC)
				esc_state = ESC_SEEN;
		end else begin
			note(KIND_ECHO, ch, 0);
			if (line_count < LINE_DEPTH) begin
				line_buf[line_count] = ch;
				line_count++;
			end
			if (line_count >= limit_in_use()) begin
				note(KIND_OVER, '0, 0);
				line_count = 0;
				n_over++;
			end
		end
		if (burst.size() > 0)
			n_busy++;
		foreach (burst[i]) begin
			r = burst[i];
			r.last = (i == burst.size() - 1);
			expected_results.push_back(r);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		res_t got;
		res_t want;
		if (!arst_n) begin
			line_count = 0;
			esc_state  = ESC_IDLE;
			line_limit = LIMIT_RESET;
			expected_results.delete();
			n_bad      = 0;
			n_busy     = 0;
			n_checked  = 0;
			n_over     = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = '{kind: kind_t'(m_axis_tuser), byte_value: m_axis_tdata[7:0],
					line_length: m_axis_tdata[12:8], last: m_axis_tlast};
				n_checked++;
				if (expected_results.size() == 0) begin
					if (n_bad < 10)
						$display("%0t: unexpected result kind %0d byte %h len %0d last %b",
							$realtime, got.kind, got.byte_value, got.line_length, got.last);
					n_bad++;
				end else begin
					want = expected_results.pop_front();
					if (got.kind != want.kind || got.byte_value != want.byte_value ||
							got.line_length != want.line_length || got.last != want.last) begin
						if (n_bad < 10)
							$display("%0t: result mismatch, expected kind %0d byte %h len %0d last %b, got kind %0d byte %h len %0d last %b",
								$realtime, want.kind, want.byte_value, want.line_length,
								want.last, got.kind, got.byte_value, got.line_length, got.last);
						n_bad++;
					end
				end
			end
			if (cfg_we)
				line_limit = cfg_wdata;
			if (s_axis_tvalid && s_axis_tready)
				edit_line(s_axis_tdata);
		end
		mismatches <= n_bad;
		pending    <= expected_results.size();
		busy_bytes <= n_busy;
		checked    <= n_checked;
		overflows  <= n_over;
	end

endmodule

[tb/console_line_editor_tb.sv]
`timescale 1ns / 100ps
module console_line_editor_tb;
	import cle_pkg::*;

	localparam int LINE_DEPTH = 32;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [LIMIT_W-1:0] cfg_wdata;
	logic               s_axis_tvalid;
	logic               s_axis_tready;
	logic [7:0]         s_axis_tdata;   // [7:0] rx_byte
	logic               m_axis_tvalid;
	logic               m_axis_tready;
	logic [15:0]        m_axis_tdata;   // [7:0] byte_value, [12:8] line_length
	logic [1:0]         m_axis_tuser;   // [1:0] kind
	logic               m_axis_tlast;

	int mismatches;
	int pending;
	int busy_bytes;
	int checked;
	int overflows;

	// idling switches, changed between phases by the stimulus
	bit src_gaps;
	bit sink_stalls;
	int sent;
	int n_limits;

	console_line_editor #(
		.LINE_DEPTH(LINE_DEPTH)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	// predicts and compares every result transaction on its own
	console_line_editor_checker #(
		.LINE_DEPTH(LINE_DEPTH)
	) i_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast),
		.mismatches   (mismatches),
		.pending      (pending),
		.busy_bytes   (busy_bytes),
		.checked      (checked),
		.overflows    (overflows)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#(20_000_000);
		$display("Test completed with failures");
		$finish;
	end

	// result sink: when sink_stalls is set, draws a random stall before taking each result
	initial begin : sink
		int stall;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			stall = sink_stalls ? $urandom_range(0, 13) : 0;
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	// one received byte; valid stays high between back-to-back transactions
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = src_gaps ? $urandom_range(0, 13) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		do @(posedge clk); while (!s_axis_tready);
		sent++;
	endtask

	// stop sending, wait for every expected result, then cover bytes that
	// gave no result and may still be in the sequencer
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_limit(input logic [LIMIT_W-1:0] v);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		n_limits++;
	endtask

	// one piece of typing: mostly words, edits, escape sequences and line ends,
	// with some raw noise bytes mixed in
	task automatic type_phrase();
		int pick;
		int n;
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			// short words usually, sometimes long enough to overflow any limit
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 34) : $urandom_range(1, 8);
			repeat (n) send_byte(8'($urandom_range(8'h20, 8'h7e)));
		end else if (pick < 60) begin
			send_byte($urandom_range(0, 1) ? CH_DEL : CH_BS);
		end else if (pick < 70) begin
			send_byte(CH_ESC);
			n = $urandom_range(0, 9);
			if (n < 5) begin
				// csi form: esc [ final
				send_byte(CH_LBR);
				send_byte(8'($urandom_range(8'h40, 8'h7e)));
			end else if (n < 9) begin
				send_byte(8'($urandom_range(0, 255)));
			end
			// otherwise left open, the next phrase eats the escape
		end else if (pick < 85) begin
			send_byte($urandom_range(0, 1) ? CH_LF : CH_CR);
		end else begin
			send_byte(8'($urandom_range(0, 255)));
		end
	endtask

	initial begin : stimulus
		logic [7:0]         opening [24];
		logic [LIMIT_W-1:0] settings [9];
		int                 goal;

		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		src_gaps      = 1'b0;
		sink_stalls   = 1'b0;
		sent          = 0;
		n_limits      = 0;

		// directed opening at the reset limit of 32:
		// empty cr and lf, erase on empty line, extreme and control bytes,
		// erase by bs and del, lf ending a line, escape on empty line,
		// esc erasing with csi form, line end while an escape is pending,
		// esc followed by esc, '[' as a plain character
		opening = '{CH_CR, CH_LF, CH_BS, 8'h00, 8'hff, 8'h01, 8'h41, CH_BS,
			CH_DEL, CH_LF, CH_ESC, 8'h41, 8'h61, 8'h62, CH_ESC, CH_LBR,
			CH_LBR, CH_ESC, CH_CR, 8'h7a, CH_ESC, CH_ESC, CH_LBR, CH_CR};

		// limits: extremes, out-of-range values acting as 1 and as the depth,
		// and a couple of random ones
		settings = '{6'd1, 6'd63, 6'd0, 6'd2, 6'd33, 6'd31, 6'd3, 6'd32, 6'd1};
		settings[6] = LIMIT_W'($urandom_range(3, 30));
		settings[8] = LIMIT_W'($urandom_range(1, 32));

		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_gaps    = 1'b1;
		sink_stalls = 1'b1;
		foreach (opening[i]) send_byte(opening[i]);

		// random phases: each idling mix, including none at all
		for (int i = 0; i < 9; i++) begin
			set_limit(settings[i]);
			src_gaps    = i[0];
			sink_stalls = i[1];
			goal = busy_bytes + 22;
			while (busy_bytes < goal) type_phrase();
		end

		settle();
		$display("sent %0d bytes across %0d limit settings, %0d of them gave results",
			sent, n_limits, busy_bytes);
		$display("compared %0d result transactions, %0d overflows among them",
			checked, overflows);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
